// ----- rtl/assert_macros.svh -----
// assertion helpers included by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`endif

// ----- rtl/pfpa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package pfpa_pkg;
  localparam int unsigned FracBits = 24;
  localparam logic [63:0] Sat63 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [47:0] F48Max = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] F48Min = 48'h8000_0000_0000;
  localparam logic [63:0] Cap48 = 64'h0001_0000_0000_0000;

  // register indexes
  localparam logic RegWellDepth = 1'b0;
  localparam logic RegSigma     = 1'b1;

  // interaction kinds
  localparam logic OpLj      = 1'b0;
  localparam logic OpCoulomb = 1'b1;

  // operand select for the shared multiplier and divider
  localparam logic [4:0] SelU    = 5'd0;
  localparam logic [4:0] SelU2   = 5'd1;
  localparam logic [4:0] SelU4   = 5'd2;
  localparam logic [4:0] SelU6   = 5'd3;
  localparam logic [4:0] SelU12  = 5'd4;
  localparam logic [4:0] SelPot  = 5'd5;
  localparam logic [4:0] SelFn   = 5'd6;
  localparam logic [4:0] SelFm   = 5'd7;
  localparam logic [4:0] SelCp   = 5'd8;
  localparam logic [4:0] SelCf   = 5'd9;
  localparam logic [4:0] SelMx   = 5'd10;
  localparam logic [4:0] SelDx   = 5'd11;
  localparam logic [4:0] SelMy   = 5'd12;
  localparam logic [4:0] SelDy   = 5'd13;
  localparam logic [4:0] SelMz   = 5'd14;
  localparam logic [4:0] SelDz   = 5'd15;

  typedef struct packed {
    logic       load;     // capture input item
    logic       op_go;    // start one arithmetic step
    logic [4:0] op_sel;   // which step
    logic       finish;   // publish result
  } pfpa_cmd_t;

  typedef struct packed {
    logic op_done;
    logic zero;
    logic kind;
  } pfpa_sts_t;
endpackage
`default_nettype wire

// ----- rtl/pfpa_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pfpa_ctrl
  import pfpa_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_fire_i,
  input  wire logic      out_free_i,
  input  wire pfpa_sts_t sts_i,
  output pfpa_cmd_t      cmd_o,
  output logic           busy_o
);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StWait = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [4:0] sel_q, sel_d;

  // step sequencing
  always_comb begin
    state_d = state_q;
    sel_d = sel_q;
    cmd_o = '0;
    cmd_o.op_sel = sel_q;
    case (state_q)
      StIdle: begin
        if (in_fire_i) begin
          cmd_o.load = 1'b1;
          state_d = StRun;
        end
      end
      StRun: begin
        if (sts_i.zero) begin
          state_d = StOut;
        end else begin
          cmd_o.op_go = 1'b1;
          state_d = StWait;
        end
      end
      StWait: begin
        if (sts_i.op_done) begin
          state_d = StRun;
          if (sel_q == SelDz) begin
            state_d = StOut;
          end else if (sel_q == SelFm && sts_i.kind == OpLj) begin
            sel_d = SelMx;
          end else if (sel_q == SelU12) begin
            sel_d = SelPot;
          end else if (sel_q == SelU && sts_i.kind == OpCoulomb) begin
            sel_d = SelCf;
          end else if (sel_q == SelCf) begin
            sel_d = SelMx;
          end else begin
            sel_d = sel_q + 5'd1;
          end
        end
      end
      StOut: begin
        if (out_free_i) begin
          cmd_o.finish = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    if (cmd_o.load) sel_d = SelU;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      sel_q <= SelU;
    end else begin
      state_q <= state_d;
      sel_q <= sel_d;
    end
  end

  assign busy_o = (state_q != StIdle);
endmodule
`default_nettype wire

// ----- rtl/pfpa_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pfpa_dp
  import pfpa_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire pfpa_cmd_t    cmd_i,
  output pfpa_sts_t         sts_o,
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_idx_i,
  input  wire logic [31:0]  cfg_data_i,
  input  wire logic [138:0] in_data_i,
  input  wire logic         in_start_i,
  output logic [192:0]      res_o
);
  logic [31:0] eps_q, sig_q;
  logic        kind_q, zero_q;
  logic [31:0] r_q;
  logic [31:0] smag_q [3];
  logic [2:0]  sneg_q;
  logic [9:0]  qprod_q;
  logic        qneg_q;
  logic [47:0] sum_q [3];
  logic [47:0] pot_q;
  logic [63:0] u_q, u2_q, u4_q, u6_q, u12_q, fmag_q, t_q;
  logic        fneg_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= 32'h0100_0000;
      sig_q <= 32'h0100_0000;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegWellDepth) eps_q <= cfg_data_i;
      else sig_q <= cfg_data_i;
    end
  end

  logic [63:0] e4;
  assign e4 = {30'd0, eps_q, 2'b00};

  // abs difference helpers for the Lennard-Jones terms
  logic        pneg, fdneg;
  logic [63:0] pd, u12k, u6k, fd;
  assign pneg = u6_q > u12_q;
  assign pd = pneg ? u6_q - u12_q : u12_q - u6_q;
  assign u12k = (u12_q > Sat63 / 12) ? Sat63 : u12_q * 64'd12;
  assign u6k  = (u6_q > Sat63 / 6) ? Sat63 : u6_q * 64'd6;
  assign fdneg = u6k > u12k;
  assign fd = fdneg ? u6k - u12k : u12k - u6k;

  // operand routing into the shared multiplier and divider
  logic [63:0] ma, mb, na, nb;
  logic        is_div;
  logic [1:0]  ax;
  always_comb begin
    ma = '0; mb = '0; na = '0; nb = {32'd0, r_q}; is_div = 1'b0; ax = 2'd0;
    case (cmd_i.op_sel)
      SelU:   begin
        is_div = 1'b1;
        na = (kind_q == OpLj) ? {32'd0, sig_q} : {30'd0, qprod_q, 24'd0};
      end
      SelU2:  begin ma = u_q;   mb = u_q;   end
      SelU4:  begin ma = u2_q;  mb = u2_q;  end
      SelU6:  begin ma = u4_q;  mb = u2_q;  end
      SelU12: begin ma = u6_q;  mb = u6_q;  end
      SelPot: begin ma = e4;    mb = pd;    end
      SelFn:  begin ma = e4;    mb = fd;    end
      SelFm:  begin is_div = 1'b1; na = t_q; end
      SelCp:  begin is_div = 1'b1; na = t_q; end
      SelCf:  begin is_div = 1'b1; na = u_q; end
      SelMx:  begin ma = fmag_q; mb = {32'd0, smag_q[0]}; end
      SelDx:  begin is_div = 1'b1; na = t_q; ax = 2'd0; end
      SelMy:  begin ma = fmag_q; mb = {32'd0, smag_q[1]}; end
      SelDy:  begin is_div = 1'b1; na = t_q; ax = 2'd1; end
      SelMz:  begin ma = fmag_q; mb = {32'd0, smag_q[2]}; end
      SelDz:  begin is_div = 1'b1; na = t_q; ax = 2'd2; end
      default: ;
    endcase
  end

  logic        mdone, ddone;
  logic [63:0] mres, dres;
  pfpa_mul u_mul (
    .clk_i(clk_i), .rst_ni(rst_ni), .go_i(cmd_i.op_go && !is_div),
    .a_i(ma), .b_i(mb), .done_o(mdone), .p_o(mres)
  );
  pfpa_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .go_i(cmd_i.op_go && is_div),
    .a_i(na), .b_i(nb), .done_o(ddone), .q_o(dres)
  );

  logic [63:0] res;
  assign res = mdone ? mres : dres;

  // accumulate one component
  logic [63:0] dmag;
  logic        dneg;
  logic [49:0] acc;
  logic [47:0] accsat;
  always_comb begin
    dmag = (dres > Cap48) ? Cap48 : dres;
    dneg = sneg_q[ax] ^ fneg_q;
    acc = {{2{sum_q[ax][47]}}, sum_q[ax]} +
          (dneg ? -{1'b0, dmag[48:0]} : {1'b0, dmag[48:0]});
    if (!acc[49] && acc[48:47] != 2'b00) accsat = F48Max;
    else if (acc[49] && acc[48:47] != 2'b11) accsat = F48Min;
    else accsat = acc[47:0];
  end

  function automatic logic [47:0] clamp48(input logic neg, input logic [63:0] mag);
    if (neg) return (mag > 64'h8000_0000_0000) ? F48Min : 48'(-mag);
    return (mag > {16'd0, F48Max}) ? F48Max : mag[47:0];
  endfunction

  logic signed [4:0] ca, cb;
  logic signed [9:0] qp;
  assign ca = in_data_i[132:128];
  assign cb = in_data_i[137:133];
  assign qp = ca * cb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q[0] <= '0; sum_q[1] <= '0; sum_q[2] <= '0;
      zero_q <= 1'b0;
      kind_q <= OpLj;
    end else if (cmd_i.load) begin
      if (in_start_i) begin
        sum_q[0] <= '0; sum_q[1] <= '0; sum_q[2] <= '0;
      end
      zero_q <= (in_data_i[127:96] == 32'd0);
      kind_q <= in_data_i[138];
    end else if (ddone && (cmd_i.op_sel == SelDx || cmd_i.op_sel == SelDy ||
                           cmd_i.op_sel == SelDz)) begin
      sum_q[ax] <= accsat;
    end
  end

  // payload captures
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      r_q <= in_data_i[127:96];
      smag_q[0] <= in_data_i[31] ? -in_data_i[31:0] : in_data_i[31:0];
      smag_q[1] <= in_data_i[63] ? -in_data_i[63:32] : in_data_i[63:32];
      smag_q[2] <= in_data_i[95] ? -in_data_i[95:64] : in_data_i[95:64];
      sneg_q <= {in_data_i[95], in_data_i[63], in_data_i[31]};
      qneg_q <= qp[9];
      qprod_q <= qp[9] ? -qp : qp;
      pot_q <= '0;
      fneg_q <= 1'b0;
    end else if (mdone || ddone) begin
      case (cmd_i.op_sel)
        SelU:   begin u_q <= res; t_q <= res; end
        SelU2:  u2_q <= res;
        SelU4:  u4_q <= res;
        SelU6:  u6_q <= res;
        SelU12: u12_q <= res;
        SelPot: pot_q <= clamp48(pneg, res);
        SelFn:  begin t_q <= res; fneg_q <= fdneg; end
        SelFm:  fmag_q <= res;
        SelCf:  begin
          fmag_q <= res; fneg_q <= qneg_q; pot_q <= clamp48(qneg_q, u_q);
        end
        default: t_q <= res;
      endcase
    end
  end

  assign sts_o.op_done = mdone || ddone;
  assign sts_o.zero = zero_q;
  assign sts_o.kind = kind_q;
  assign res_o = {zero_q, pot_q, sum_q[2], sum_q[1], sum_q[0]};
endmodule
`default_nettype wire

// ----- rtl/pfpa_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pfpa_mul
  import pfpa_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        go_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic             done_o,
  output logic [63:0]      p_o
);
  // four 32x32 partial products, one per cycle
  logic [2:0]   cnt_q;
  logic         busy_q;
  logic [63:0]  a_q, b_q;
  logic [127:0] acc_q;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [6:0]   sh;

  always_comb begin
    case (cnt_q[1:0])
      2'd0: begin pa = a_q[31:0];  pb = b_q[31:0];  sh = 7'd0;  end
      2'd1: begin pa = a_q[31:0];  pb = b_q[63:32]; sh = 7'd32; end
      2'd2: begin pa = a_q[63:32]; pb = b_q[31:0];  sh = 7'd32; end
      default: begin pa = a_q[63:32]; pb = b_q[63:32]; sh = 7'd64; end
    endcase
    pp = pa * pb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1;
        cnt_q <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  logic [127:0] shr;
  assign shr = acc_q >> FracBits;

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      a_q <= a_i; b_q <= b_i; acc_q <= '0;
    end else if (busy_q && cnt_q < 3'd4) begin
      acc_q <= acc_q + ({64'd0, pp} << sh);
    end else if (busy_q) begin
      p_o <= (shr[127:63] != '0) ? Sat63 : shr[63:0];
    end
  end
endmodule
`default_nettype wire

// ----- rtl/pfpa_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pfpa_div
  import pfpa_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        go_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic             done_o,
  output logic [63:0]      q_o
);
  // restoring divider, four quotient bits per cycle over 88 bits
  logic [87:0] num_q, quo_q;
  logic [64:0] rem_q;
  logic [63:0] b_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic [87:0] num_n, quo_n;
  logic [64:0] rem_n;

  always_comb begin
    num_n = num_q; quo_n = quo_q; rem_n = rem_q;
    for (int i = 0; i < 4; i++) begin
      rem_n = {rem_n[63:0], num_n[87]};
      num_n = {num_n[86:0], 1'b0};
      quo_n = {quo_n[86:0], 1'b0};
      if (rem_n >= {1'b0, b_q}) begin
        rem_n = rem_n - {1'b0, b_q};
        quo_n[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0; done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1; cnt_q <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd22) begin
          busy_q <= 1'b0; done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      num_q <= {a_i, 24'd0}; quo_q <= '0; rem_q <= '0; b_q <= b_i;
    end else if (busy_q && cnt_q < 5'd22) begin
      num_q <= num_n; quo_q <= quo_n; rem_q <= rem_n;
    end else if (busy_q) begin
      q_o <= (quo_q[87:63] != '0) ? Sat63 : quo_q[63:0];
    end
  end
endmodule
`default_nettype wire

// ----- rtl/pair_force_potential_accumulator.sv -----
// pair force and potential accumulator
// input stream s_axis: one atom pair per request; output stream m_axis:
// one result per pair (three accumulated force components, the pair
// potential and a zero-distance flag).
// config: cfg_we_i/cfg_idx_i/cfg_data_i write epsilon (0) and sigma (1); the user
// must write them only while the block is idle, the block does not enforce it.
// a Lennard-Jones or Coulomb pair is computed step by step on one shared
// 64-bit multiplier (four 32x32 partial products a step) and one 88-bit
// divider (four bits per cycle); a zero-distance pair skips the steps.
// one pair is in flight at a time; the next is taken the cycle after the
// result has moved to the output register.
// reset clears the force sum, restores epsilon and sigma to 1.0 and
// empties the output register.
// a stalled receiver holds the result; the block then waits before
// publishing the next one.
`timescale 1ns / 1ps
`default_nettype none
module pair_force_potential_accumulator
  import pfpa_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // opcode, start_req, sep_x, sep_y, sep_z, distance, charge_first,
  // charge_second from bit 0 up, zero fill
  input  wire logic [143:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // force_x, force_y, force_z, pair_potential, zero_distance, zero fill
  output logic [199:0]      m_axis_tdata,
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_idx_i,
  input  wire logic [31:0]  cfg_data_i
);
  pfpa_cmd_t cmd;
  pfpa_sts_t sts;
  logic      busy, in_fire, out_free;
  logic [192:0] res;

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  pfpa_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_fire_i(in_fire), .out_free_i(out_free),
    .sts_i(sts), .cmd_o(cmd), .busy_o(busy)
  );

  pfpa_dp u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd), .sts_o(sts),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .in_data_i({s_axis_tdata[0], s_axis_tdata[139:130], s_axis_tdata[129:2]}),
    .in_start_i(s_axis_tdata[1]), .res_o(res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.finish) m_axis_tdata <= {7'd0, res};
  end
endmodule
`default_nettype wire

// ----- rtl/pfpa_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pfpa_props (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [199:0] m_axis_tdata
);
  `ASSERT_CLK(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `ASSERT_CLK(a_one_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
  `ASSERT_CLK(a_pad, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tdata[199:193] == 7'd0)
  `ASSERT_CLK(a_zero_pot, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[192] |-> m_axis_tdata[191:144] == 48'd0)
endmodule
bind pair_force_potential_accumulator pfpa_props u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
